### hw/rtl/boxf3_pkg.sv
package boxf3_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_SIZE_DEF     = 1024;
    localparam int CHANNEL_BITS_DEF = 16;

    // Fixed field and port widths.
    localparam int CFG_W   = 11;
    localparam int FIELD_W = 16;
    localparam int NUM_CH  = 3;
    localparam int DATA_W  = NUM_CH * FIELD_W;

    // Image size after reset.
    localparam int SIZE_RESET = 32;

    // Depth of the result queue in front of the output port.
    localparam int FIFO_DEPTH = 8;

    // Divisor selected by how many pixels of the window lie inside the image.
    typedef enum logic [2:0] {
        DIV4 = 3'b001,
        DIV6 = 3'b010,
        DIV9 = 3'b100
    } div_kind_t;

    // Control carried with an item from the accept stage to the window stage.
    typedef struct packed {
        logic      emit;
        logic      shift;
        logic      col_top;
        logic      col_bot;
        logic      left_clip;
        logic      right_edge;
        div_kind_t div_kind;
        logic      frame_end;
    } item_ctl_t;

endpackage

### hw/rtl/boxf3_ram.sv
module boxf3_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/box_filter_3x3_clipped_rgb.sv
// 3x3 mean filter for a square RGB image streamed in raster order.
// Input channel (s_*): one transfer per pixel (s_tuser = 0) or per flush
// (s_tuser = 1). A frame is image_size x image_size pixels followed by
// image_size + 1 flushes; pixels beyond the frame and early flushes are
// dropped without a result.
// Output channel (m_*): one transfer per result, in raster order, carrying
// the truncated per-channel mean over the window clipped at the borders.
// m_tlast marks the bottom-right pixel; the next frame starts after it.
// Configuration: cfg_wr_en writes image_size (clamped to 2..MAX_SIZE) and
// restarts the frame; write it only while no item is in flight.
// Throughput is one transfer per cycle on each side while the receiver
// keeps up. A result leaves the four-stage pipe (line-store read, column
// sum, window sum and reciprocal multiply) after the transfer that
// completes its window and then waits in an eight-entry queue.
// When the receiver stalls, the queue fills and s_tready falls once eight
// results are pending; nothing is lost. Two rows of history sit in one
// line store, read at the column of the incoming pixel and written back in
// the following cycle.
// Reset: image_size is 32, the frame position is zero, the queue is empty.
module box_filter_3x3_clipped_rgb #(
    parameter int MAX_SIZE     = boxf3_pkg::MAX_SIZE_DEF,
    parameter int CHANNEL_BITS = boxf3_pkg::CHANNEL_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [boxf3_pkg::CFG_W-1:0]  cfg_wr_data,  // image_size
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [boxf3_pkg::DATA_W-1:0] s_tdata,      // red_in, green_in, blue_in
    input  logic                         s_tuser,      // opcode
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [boxf3_pkg::DATA_W-1:0] m_tdata,      // red_out, green_out, blue_out
    output logic                         m_tlast       // frame_end
);

    import boxf3_pkg::*;

    localparam int SIZE_W  = $clog2(MAX_SIZE + 1);
    localparam int ADDR_W  = $clog2(MAX_SIZE);
    localparam int CB      = CHANNEL_BITS;
    localparam int COL_W   = CB + 2;
    localparam int SUM_W   = CB + 4;
    localparam int SHIFT   = CB + 8;
    localparam int MULT_W  = CB + 7;
    localparam int PROD_W  = SUM_W + MULT_W;
    localparam int PIX_W   = NUM_CH * CB;
    localparam int PTR_W   = $clog2(FIFO_DEPTH);
    localparam int CRED_W  = $clog2(FIFO_DEPTH + 1);
    localparam int RESET_N = (SIZE_RESET > MAX_SIZE) ? MAX_SIZE : SIZE_RESET;

    // Reciprocals scaled by 2^SHIFT; exact truncation for every window sum.
    localparam longint unsigned ONE_SHIFT = 64'd1 << SHIFT;
    localparam logic [MULT_W-1:0] MULT4 = MULT_W'(ONE_SHIFT / 4);
    localparam logic [MULT_W-1:0] MULT6 = MULT_W'((ONE_SHIFT + 5) / 6);
    localparam logic [MULT_W-1:0] MULT9 = MULT_W'((ONE_SHIFT + 8) / 9);

    typedef struct packed {
        logic                             last;
        logic [NUM_CH-1:0][FIELD_W-1:0]   chans;
    } out_entry_t;

    // Frame size and raster position of the next input.
    logic [SIZE_W-1:0] size_reg, size_next, size_cfg;
    logic [SIZE_W-1:0] x_reg, x_next;
    logic [SIZE_W-1:0] y_reg, y_next;
    logic [CRED_W-1:0] cred_reg, cred_next;

    logic      accept;
    logic      act;
    logic      full;
    logic      x_zero;
    logic      x_at_end;
    logic      e_top;
    logic      e_bot;
    logic      two_cols;
    logic      two_rows;
    item_ctl_t ctl;

    // Pipeline registers.
    logic                           v1_reg;
    item_ctl_t                      ctl1_reg;
    logic [PIX_W-1:0]               pix1_reg;
    logic [ADDR_W-1:0]              addr1_reg;
    logic [2*PIX_W-1:0]             rd_data;
    logic [2*PIX_W-1:0]             wr_data;
    logic                           ram_wr_en;

    logic [NUM_CH-1:0][COL_W-1:0]   colsum;
    logic [NUM_CH-1:0][COL_W-1:0]   wl_reg;
    logic [NUM_CH-1:0][COL_W-1:0]   wr_reg;

    logic                           v2_reg;
    logic [NUM_CH-1:0][COL_W-1:0]   a2_reg;
    logic [NUM_CH-1:0][COL_W-1:0]   b2_reg;
    logic [NUM_CH-1:0][COL_W-1:0]   c2_reg;
    div_kind_t                      div2_reg;
    logic                           fe2_reg;

    logic                           v3_reg;
    logic [NUM_CH-1:0][SUM_W-1:0]   sum3_reg;
    div_kind_t                      div3_reg;
    logic                           fe3_reg;
    logic [MULT_W-1:0]              mult;

    logic                           v4_reg;
    logic [NUM_CH-1:0][PROD_W-1:0]  prod4_reg;
    logic                           fe4_reg;
    out_entry_t                     fifo_in;

    out_entry_t                     fifo_mem_reg [FIFO_DEPTH];
    logic [PTR_W:0]                 wr_ptr_reg, wr_ptr_next;
    logic [PTR_W:0]                 rd_ptr_reg, rd_ptr_next;
    logic                           pop;
    out_entry_t                     fifo_out;

    // Clamp a written size to the supported range.
    always_comb
    begin
        if (cfg_wr_data < CFG_W'(2))
        begin
            size_cfg = SIZE_W'(2);
        end
        else if (32'(cfg_wr_data) > 32'(MAX_SIZE))
        begin
            size_cfg = SIZE_W'(MAX_SIZE);
        end
        else
        begin
            size_cfg = SIZE_W'(cfg_wr_data);
        end
    end

    // Classify the incoming item from the current raster position.
    assign s_tready = (cred_reg < CRED_W'(FIFO_DEPTH));
    assign accept   = s_tvalid && s_tready;
    assign full     = (y_reg == size_reg);
    assign x_zero   = (x_reg == '0);
    assign x_at_end = (x_reg == size_reg);
    assign act      = s_tuser ? full : !full;
    assign e_top    = x_zero ? (y_reg == SIZE_W'(2)) : (y_reg == SIZE_W'(1));
    assign e_bot    = !x_zero && full;
    assign two_cols = x_zero || x_at_end || (x_reg == SIZE_W'(1));
    assign two_rows = e_top || e_bot;

    always_comb
    begin
        ctl.emit       = act && (x_zero ? (y_reg > SIZE_W'(1)) : (y_reg != '0));
        ctl.shift      = act && !x_at_end;
        ctl.col_top    = (y_reg == SIZE_W'(1));
        ctl.col_bot    = full;
        ctl.left_clip  = (x_reg == SIZE_W'(1));
        ctl.right_edge = x_zero || x_at_end;
        ctl.frame_end  = full && x_at_end;
        if (two_cols && two_rows)
        begin
            ctl.div_kind = DIV4;
        end
        else if (two_cols || two_rows)
        begin
            ctl.div_kind = DIV6;
        end
        else
        begin
            ctl.div_kind = DIV9;
        end
    end

    // Position counters, frame size and result credits.
    always_comb
    begin
        size_next = size_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        cred_next = cred_reg;
        if (cfg_wr_en)
        begin
            size_next = size_cfg;
            x_next    = '0;
            y_next    = '0;
        end
        else if (accept && act)
        begin
            if (x_at_end)
            begin
                x_next = '0;
                y_next = '0;
            end
            else if (!s_tuser && (x_reg == size_reg - SIZE_W'(1)))
            begin
                x_next = '0;
                y_next = y_reg + SIZE_W'(1);
            end
            else
            begin
                x_next = x_reg + SIZE_W'(1);
            end
        end
        if (accept && ctl.emit && !pop)
        begin
            cred_next = cred_reg + CRED_W'(1);
        end
        else if (!(accept && ctl.emit) && pop)
        begin
            cred_next = cred_reg - CRED_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_W'(RESET_N);
            x_reg    <= '0;
            y_reg    <= '0;
            cred_reg <= '0;
        end
        else
        begin
            size_reg <= size_next;
            x_reg    <= x_next;
            y_reg    <= y_next;
            cred_reg <= cred_next;
        end
    end

    // Line store: lower half is the row two above, upper half the row above.
    assign ram_wr_en = v1_reg && ctl1_reg.shift && !ctl1_reg.col_bot;
    assign wr_data   = {pix1_reg, rd_data[PIX_W +: PIX_W]};

    boxf3_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_SIZE)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (addr1_reg),
        .wr_data (wr_data),
        .rd_en   (accept && ctl.shift),
        .rd_addr (x_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    // Stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept && act;
            v2_reg <= v1_reg && ctl1_reg.emit;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Capture the accepted pixel, keeping the low channel bits.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ctl1_reg  <= ctl;
            addr1_reg <= x_reg[ADDR_W-1:0];
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                pix1_reg[ch*CB +: CB] <= s_tdata[ch*FIELD_W +: CB];
            end
        end
    end

    // Column sum of the new column with row clipping applied.
    always_comb
    begin
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            colsum[ch] = (ctl1_reg.col_top ? COL_W'(0) : COL_W'(rd_data[ch*CB +: CB]))
                       + COL_W'(rd_data[PIX_W + ch*CB +: CB])
                       + (ctl1_reg.col_bot ? COL_W'(0) : COL_W'(pix1_reg[ch*CB +: CB]));
        end
    end

    // Window columns: shift in the new column and pick the three in use.
    always_ff @(posedge clk)
    begin
        if (v1_reg && ctl1_reg.shift)
        begin
            wl_reg <= wr_reg;
            wr_reg <= colsum;
        end
        if (v1_reg)
        begin
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                a2_reg[ch] <= ctl1_reg.left_clip ? COL_W'(0) : wl_reg[ch];
                b2_reg[ch] <= wr_reg[ch];
                c2_reg[ch] <= ctl1_reg.right_edge ? COL_W'(0) : colsum[ch];
            end
            div2_reg <= ctl1_reg.div_kind;
            fe2_reg  <= ctl1_reg.frame_end;
        end
    end

    // Window sum.
    always_ff @(posedge clk)
    begin
        if (v2_reg)
        begin
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                sum3_reg[ch] <= SUM_W'(a2_reg[ch]) + SUM_W'(b2_reg[ch]) + SUM_W'(c2_reg[ch]);
            end
            div3_reg <= div2_reg;
            fe3_reg  <= fe2_reg;
        end
    end

    // Division by the pixel count as a multiply by its scaled reciprocal.
    always_comb
    begin
        unique case (div3_reg)
            DIV4:    mult = MULT4;
            DIV6:    mult = MULT6;
            DIV9:    mult = MULT9;
            default: mult = MULT9;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (v3_reg)
        begin
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                prod4_reg[ch] <= PROD_W'(sum3_reg[ch]) * PROD_W'(mult);
            end
            fe4_reg <= fe3_reg;
        end
    end

    always_comb
    begin
        fifo_in.last = fe4_reg;
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            fifo_in.chans[ch] = FIELD_W'(prod4_reg[ch][SHIFT +: CB]);
        end
    end

    // Result queue; credits keep it from overflowing.
    assign pop         = m_tvalid && m_tready;
    assign wr_ptr_next = v4_reg ? wr_ptr_reg + (PTR_W+1)'(1) : wr_ptr_reg;
    assign rd_ptr_next = pop ? rd_ptr_reg + (PTR_W+1)'(1) : rd_ptr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (v4_reg)
        begin
            fifo_mem_reg[wr_ptr_reg[PTR_W-1:0]] <= fifo_in;
        end
    end

    assign fifo_out = fifo_mem_reg[rd_ptr_reg[PTR_W-1:0]];
    assign m_tvalid = (wr_ptr_reg != rd_ptr_reg);
    assign m_tdata  = fifo_out.chans;
    assign m_tlast  = fifo_out.last;

endmodule
